// ----- hdl/mbist_pkg.sv -----
`default_nettype none

package mbist_pkg;

    // Field widths fixed by the interface
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 5;
    localparam int PHASE_W  = 3;
    localparam int KIND_W   = 2;
    localparam int REGION_W = 6;

    // Defaults
    localparam int MAX_WORDS_DEF = 32;
    localparam logic [REGION_W-1:0] REGION_RST = 6'd20;

    // Depth of the input and result queues
    localparam int QUEUE_DEPTH = 2;

    // Input action codes
    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_DATA  = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_READ     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MISMATCH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

    // March elements, test then replay
    localparam logic [PHASE_W-1:0] PH_S1  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_S2  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_S3  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_S4  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_S1S = 3'd4;
    localparam logic [PHASE_W-1:0] PH_S2S = 3'd5;
    localparam logic [PHASE_W-1:0] PH_S3S = 3'd6;
    localparam logic [PHASE_W-1:0] PH_S4S = 3'd7;

    // Classified input beat
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] data;
    } item_t;

    // One result beat
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] word_index;
        logic [DATA_W-1:0]  write_data;
        logic [DATA_W-1:0]  signature;
        logic [DATA_W-1:0]  expected;
        logic [PHASE_W-1:0] phase;
        logic               last;
    } result_t;

    // Signature step: fold in the word, feed back bit31^bit30 into bit0, rotate right
    function automatic logic [DATA_W-1:0] sig_update(input logic [DATA_W-1:0] s,
                                                     input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] t;
        t    = s ^ v;
        t[0] = t[0] ^ t[DATA_W-1] ^ t[DATA_W-2];
        return {t[0], t[DATA_W-1:1]};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mbist_ram.sv -----
`default_nettype none

module mbist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mbist_front.sv -----
`default_nettype none

module mbist_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic                        action,
    input  wire logic [mbist_pkg::DATA_W-1:0] read_data,
    output logic                             item_valid,
    output mbist_pkg::item_t                 item,
    input  wire logic                        item_pop
);

    import mbist_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              wr_en;
    item_t             in_item;

    // Classify the incoming beat
    always_comb
    begin
        in_item.start = (action == ACTION_START);
        in_item.data  = read_data;
    end

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign wr_en      = push && !full;
    assign item_valid = (count_reg != '0);
    assign item       = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (item_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !item_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && item_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mbist_resq.sv -----
`default_nettype none

module mbist_resq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                res_push,
    input  wire mbist_pkg::result_t  res_in,
    output logic                     res_full,
    output logic                     empty,
    input  wire logic                pop,
    output mbist_pkg::result_t       res_out
);

    import mbist_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rd_en;

    assign res_full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_en    = pop && !empty;
    assign res_out  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (res_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (res_push && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!res_push && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            slot_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mbist_back.sv -----
`default_nettype none

module mbist_back #(
    parameter int MAX_WORDS = mbist_pkg::MAX_WORDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [mbist_pkg::REGION_W-1:0] region_words,
    input  wire logic                          item_valid,
    input  wire mbist_pkg::item_t              item,
    output logic                               item_pop,
    input  wire logic                          res_full,
    output logic                               res_push,
    output mbist_pkg::result_t                 res
);

    import mbist_pkg::*;

    localparam int WORD_W = $clog2(MAX_WORDS);
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int CW     = (CNT_W > REGION_W) ? CNT_W : REGION_W;
    localparam int DEPTH  = 4 * MAX_WORDS;
    localparam int AW     = $clog2(DEPTH);

    // Walk state
    logic [DATA_W-1:0]  sig_reg, sig_next;
    logic [DATA_W-1:0]  final_reg, final_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic               pend_reg, pend_next;
    logic               busy_reg, busy_next;

    // Plan of the item being emitted
    logic               pl_valid_reg, pl_valid_next;
    logic [1:0]         pl_nwr_reg, pl_nwr_next;
    logic [1:0]         pl_idx_reg, pl_idx_next;
    logic               pl_chk_reg, pl_chk_next;
    logic [DATA_W-1:0]  pl_v_reg, pl_v_next;
    logic [WORD_W-1:0]  pl_w_reg, pl_w_next;
    logic [PHASE_W-1:0] pl_ph_reg, pl_ph_next;
    logic [DATA_W-1:0]  pl_sig_reg, pl_sig_next;
    logic               tl_done_reg, tl_done_next;
    logic [WORD_W-1:0]  tl_w_reg, tl_w_next;
    logic [PHASE_W-1:0] tl_ph_reg, tl_ph_next;
    logic [DATA_W-1:0]  tl_sig_reg, tl_sig_next;
    logic [DATA_W-1:0]  tl_exp_reg, tl_exp_next;

    // Region size and load-side decode
    logic [CW-1:0]      region_ext;
    logic [CW-1:0]      size;
    logic [WORD_W-1:0]  size_m1;
    logic               invert;
    logic [DATA_W-1:0]  sig_new;
    logic               adv;
    logic               desc;
    logic               last_word;
    logic [PHASE_W-1:0] phase_inc;
    logic [WORD_W-1:0]  word_first;

    // Reference store
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_addr;
    logic [DATA_W-1:0]  ref_rdata;

    // Emit side
    logic               emit_wr;
    logic               mism;
    logic               emit_mm;
    logic               emit_tl;
    logic               tail_go;

    // Effective region: zero acts as one, clamp at MAX_WORDS
    always_comb
    begin
        region_ext = CW'(region_words);
        if (region_words == '0)
        begin
            size = CW'(1);
        end
        else if (region_ext > CW'(MAX_WORDS))
        begin
            size = CW'(MAX_WORDS);
        end
        else
        begin
            size = region_ext;
        end
        size_m1 = WORD_W'(size - CW'(1));
    end

    // Signature of this read and walk decode
    always_comb
    begin
        invert = (phase_reg == PH_S3S) || (phase_reg == PH_S2S && !pend_reg)
              || (phase_reg == PH_S4S && pend_reg);
        sig_new    = sig_update(sig_reg, invert ? ~item.data : item.data);
        adv        = !phase_reg[0] || pend_reg;
        desc       = phase_reg[1];
        last_word  = desc ? (word_reg == '0) : ((CW'(word_reg) + CW'(1)) >= size);
        phase_inc  = phase_reg + 1'b1;
        word_first = phase_inc[1] ? size_m1 : '0;
    end

    // Emit stage: writes, then an optional mismatch, then the tail beat
    always_comb
    begin
        emit_wr  = pl_valid_reg && (pl_idx_reg != pl_nwr_reg);
        mism     = pl_chk_reg && (ref_rdata != pl_sig_reg);
        emit_mm  = pl_valid_reg && !emit_wr && mism;
        emit_tl  = pl_valid_reg && !emit_wr && !mism;
        res_push = pl_valid_reg && !res_full;
        tail_go  = emit_tl && !res_full;
        item_pop = item_valid && (!pl_valid_reg || tail_go);
    end

    // Result beat
    always_comb
    begin
        res            = '0;
        res.signature  = pl_sig_reg;
        res.phase      = pl_ph_reg;
        res.word_index = INDEX_W'(pl_w_reg);
        if (emit_wr)
        begin
            res.kind       = KIND_WRITE;
            res.write_data = (pl_idx_reg == 2'd1) ? pl_v_reg : ~pl_v_reg;
        end
        else if (mism)
        begin
            res.kind     = KIND_MISMATCH;
            res.expected = ref_rdata;
        end
        else
        begin
            res.kind       = tl_done_reg ? KIND_DONE : KIND_READ;
            res.word_index = INDEX_W'(tl_w_reg);
            res.phase      = tl_ph_reg;
            res.signature  = tl_sig_reg;
            res.expected   = tl_exp_reg;
            res.last       = 1'b1;
        end
    end

    // Load stage: take an item, step the walk, build the plan
    always_comb
    begin
        sig_next      = sig_reg;
        final_next    = final_reg;
        phase_next    = phase_reg;
        word_next     = word_reg;
        pend_next     = pend_reg;
        busy_next     = busy_reg;
        pl_valid_next = pl_valid_reg;
        pl_nwr_next   = pl_nwr_reg;
        pl_idx_next   = pl_idx_reg;
        pl_chk_next   = pl_chk_reg;
        pl_v_next     = pl_v_reg;
        pl_w_next     = pl_w_reg;
        pl_ph_next    = pl_ph_reg;
        pl_sig_next   = pl_sig_reg;
        tl_done_next  = tl_done_reg;
        tl_w_next     = tl_w_reg;
        tl_ph_next    = tl_ph_reg;
        tl_sig_next   = tl_sig_reg;
        tl_exp_next   = tl_exp_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_addr      = AW'(phase_reg[1:0]) * AW'(MAX_WORDS) + AW'(word_reg);

        // Progress through the current plan
        if (res_push && emit_wr)
        begin
            pl_idx_next = pl_idx_reg + 1'b1;
        end
        if (res_push && emit_mm)
        begin
            pl_chk_next = 1'b0;
        end
        if (tail_go)
        begin
            pl_valid_next = 1'b0;
        end

        if (item_pop)
        begin
            pl_idx_next = '0;
            if (item.start)
            begin
                busy_next     = 1'b1;
                sig_next      = '0;
                phase_next    = PH_S1;
                word_next     = '0;
                pend_next     = 1'b0;
                pl_valid_next = 1'b1;
                pl_nwr_next   = '0;
                pl_chk_next   = 1'b0;
                pl_w_next     = '0;
                pl_ph_next    = PH_S1;
                pl_sig_next   = '0;
                tl_done_next  = 1'b0;
                tl_w_next     = '0;
                tl_ph_next    = PH_S1;
                tl_sig_next   = '0;
                tl_exp_next   = '0;
            end
            else if (busy_reg)
            begin
                sig_next      = sig_new;
                pl_valid_next = 1'b1;
                pl_nwr_next   = phase_reg[2] ? 2'd0 : (phase_reg[0] ? 2'd1 : 2'd3);
                pl_chk_next   = phase_reg[2] && adv;
                pl_v_next     = item.data;
                pl_w_next     = word_reg;
                pl_ph_next    = phase_reg;
                pl_sig_next   = sig_new;
                tl_done_next  = 1'b0;
                tl_w_next     = word_reg;
                tl_ph_next    = phase_reg;
                tl_sig_next   = sig_new;
                tl_exp_next   = '0;
                ram_we        = adv && !phase_reg[2];
                ram_re        = adv && phase_reg[2];
                if (!adv)
                begin
                    // second read of this word
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!last_word)
                    begin
                        word_next = desc ? word_reg - 1'b1 : word_reg + 1'b1;
                        tl_w_next = word_next;
                    end
                    else if (phase_reg == PH_S4S)
                    begin
                        // end of replay
                        busy_next    = 1'b0;
                        phase_next   = PH_S1;
                        word_next    = '0;
                        tl_done_next = 1'b1;
                        tl_w_next    = '0;
                        tl_exp_next  = final_reg;
                    end
                    else
                    begin
                        if (phase_reg == PH_S4)
                        begin
                            final_next  = sig_new;
                            sig_next    = '0;
                            tl_sig_next = '0;
                        end
                        phase_next = phase_inc;
                        word_next  = word_first;
                        tl_w_next  = word_first;
                        tl_ph_next = phase_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_reg      <= '0;
            final_reg    <= '0;
            phase_reg    <= PH_S1;
            word_reg     <= '0;
            pend_reg     <= 1'b0;
            busy_reg     <= 1'b0;
            pl_valid_reg <= 1'b0;
            pl_nwr_reg   <= '0;
            pl_idx_reg   <= '0;
            pl_chk_reg   <= 1'b0;
            tl_done_reg  <= 1'b0;
        end
        else
        begin
            sig_reg      <= sig_next;
            final_reg    <= final_next;
            phase_reg    <= phase_next;
            word_reg     <= word_next;
            pend_reg     <= pend_next;
            busy_reg     <= busy_next;
            pl_valid_reg <= pl_valid_next;
            pl_nwr_reg   <= pl_nwr_next;
            pl_idx_reg   <= pl_idx_next;
            pl_chk_reg   <= pl_chk_next;
            tl_done_reg  <= tl_done_next;
        end
    end

    // Plan payload
    always_ff @(posedge clk)
    begin
        pl_v_reg   <= pl_v_next;
        pl_w_reg   <= pl_w_next;
        pl_ph_reg  <= pl_ph_next;
        pl_sig_reg <= pl_sig_next;
        tl_w_reg   <= tl_w_next;
        tl_ph_reg  <= tl_ph_next;
        tl_sig_reg <= tl_sig_next;
        tl_exp_reg <= tl_exp_next;
    end

    // Reference signatures, one per element and word
    mbist_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (sig_new),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ref_rdata)
    );

    // A start restarts the walk at the first element with a plan ready
    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_pop && item.start) |=> (busy_reg && phase_reg == PH_S1 && pl_valid_reg))
        else $error("start did not restart the walk");

    // A new item is loaded only when the old plan is finished or on its tail beat
    a_load_on_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (item_pop && pl_valid_reg) |-> tail_go)
        else $error("plan overwritten before its tail beat");

    // Mismatches only come out of replay elements
    a_mismatch_replay: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && emit_mm) |-> pl_ph_reg[2])
        else $error("mismatch reported in a test element");

    // The word pointer stays inside the reference store row
    a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_reg < WORD_W'(MAX_WORDS - 1) || word_reg == WORD_W'(MAX_WORDS - 1))
        else $error("word pointer out of range");

endmodule

`default_nettype wire

// ----- hdl/memory_march_bist_signature.sv -----
`default_nettype none

// March memory BIST with signature check. A start beat (action 0) runs four march
// elements over region_words words (S1, S2 upward, S3, S4 downward) and then a
// read-only replay that compares against the reference signature stored for every
// element and word. The block drives the memory through result beats: read
// requests, write commands, mismatch reports and a final done beat; each read
// request is answered by pushing a data beat (action 1) with the word read. Data
// beats while no run is active are dropped. The sequencer emits one result beat per
// clock while the result queue has room. A data beat causes four results in S1/S3,
// two in S2/S4 and one or two in the replay; a start causes one. Loading the next
// beat overlaps the last result of the one before. Two-entry queues sit on
// both sides. The reference store has 4*MAX_WORDS entries, is not cleared after
// reset and is only read in the replay, after the test elements have written it.
module memory_march_bist_signature #(
    parameter int MAX_WORDS = mbist_pkg::MAX_WORDS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           region_words_we,
    input  wire logic [mbist_pkg::REGION_W-1:0] region_words,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic                           action,
    input  wire logic [mbist_pkg::DATA_W-1:0]   read_data,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [mbist_pkg::KIND_W-1:0]        kind,
    output logic [mbist_pkg::INDEX_W-1:0]       word_index,
    output logic [mbist_pkg::DATA_W-1:0]        write_data,
    output logic [mbist_pkg::DATA_W-1:0]        signature,
    output logic [mbist_pkg::DATA_W-1:0]        expected,
    output logic [mbist_pkg::PHASE_W-1:0]       phase,
    output logic                                last
);

    import mbist_pkg::*;

    logic [REGION_W-1:0] region_words_reg;
    logic                item_valid;
    item_t               item;
    logic                item_pop;
    logic                res_full;
    logic                res_push;
    result_t             res_in;
    result_t             res_out;

    // Region size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_words_reg <= REGION_RST;
        end
        else if (region_words_we)
        begin
            region_words_reg <= region_words;
        end
    end

    mbist_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .read_data  (read_data),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    mbist_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .region_words (region_words_reg),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop),
        .res_full     (res_full),
        .res_push     (res_push),
        .res          (res_in)
    );

    mbist_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    // Result ports
    assign kind       = res_out.kind;
    assign word_index = res_out.word_index;
    assign write_data = res_out.write_data;
    assign signature  = res_out.signature;
    assign expected   = res_out.expected;
    assign phase      = res_out.phase;
    assign last       = res_out.last;

endmodule

`default_nettype wire

// ----- sim/memory_march_bist_signature_tb.sv -----
`timescale 1ns / 100ps

module memory_march_bist_signature_tb;

    import mbist_pkg::*;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned ITEM_TARGET  = 420;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam logic [REGION_W-1:0] WORDS_MAX = 6'd32;

    // How a directed row is checked
    typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_FIRST_READ} row_chk_t;
    // How the memory answers read requests during a run
    typedef enum logic [1:0] {MEM_GOOD, MEM_FAULT, MEM_NOISE} mem_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 region_words_we = 1'b0;
    logic [REGION_W-1:0]  region_words = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 action = ACTION_START;
    logic [DATA_W-1:0]    read_data = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [KIND_W-1:0]    kind;
    logic [INDEX_W-1:0]   word_index;
    logic [DATA_W-1:0]    write_data;
    logic [DATA_W-1:0]    signature;
    logic [DATA_W-1:0]    expected;
    logic [PHASE_W-1:0]   phase;
    logic                 last;

    // March predictor state
    logic [REGION_W-1:0]  region_reg = REGION_RST;
    logic [DATA_W-1:0]    run_sig = '0;
    logic [DATA_W-1:0]    test_sig = '0;
    logic [PHASE_W-1:0]   cur_phase = PH_S1;
    logic [INDEX_W-1:0]   cur_word = '0;
    logic                 second_rd = 1'b0;
    logic                 run_active = 1'b0;
    logic [DATA_W-1:0]    ref_sig [0:127];

    // Memory seen by the block, kept from predicted commands
    logic [DATA_W-1:0]    mem_word [0:31];
    logic [INDEX_W-1:0]   rd_addr = '0;

    result_t              step_beats[$];
    result_t              pending_cmds[$];

    logic                 tbl_act[$];
    logic [DATA_W-1:0]    tbl_data[$];
    row_chk_t             tbl_chk[$];

    int unsigned          send_gap_pct = 29;
    int unsigned          recv_gap_pct = 47;
    int unsigned          fed_items = 0;
    int unsigned          err_count = 0;
    int unsigned          quiet_cycles = 0;

    memory_march_bist_signature dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .region_words_we (region_words_we),
        .region_words    (region_words),
        .push            (push),
        .full            (full),
        .action          (action),
        .read_data       (read_data),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .word_index      (word_index),
        .write_data      (write_data),
        .signature       (signature),
        .expected        (expected),
        .phase           (phase),
        .last            (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Signature step: fold word in, feed bit31^bit30 back into bit0, rotate right
    function automatic logic [DATA_W-1:0] misr_fold(input logic [DATA_W-1:0] s,
                                                    input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] m;
        m    = s ^ v;
        m[0] = m[0] ^ (m[31] ^ m[30]);
        return {m[0], m[31:1]};
    endfunction

    // Out-of-range sizes saturate
    function automatic logic [REGION_W-1:0] region_span();
        if (region_reg == '0)
            return 6'd1;
        if (region_reg > WORDS_MAX)
            return WORDS_MAX;
        return region_reg;
    endfunction

    function automatic void put_beat(input logic [KIND_W-1:0] k, input logic [INDEX_W-1:0] w,
                                     input logic [DATA_W-1:0] wd, input logic [DATA_W-1:0] sg,
                                     input logic [DATA_W-1:0] ex);
        result_t b;
        b.kind       = k;
        b.word_index = w;
        b.write_data = wd;
        b.signature  = sg;
        b.expected   = ex;
        b.phase      = cur_phase;
        b.last       = 1'b0;
        step_beats.push_back(b);
    endfunction

    // Step to the next word or element; issue the next read or the done beat
    function automatic void next_word();
        logic [REGION_W-1:0] span;
        logic [REGION_W-1:0] top;
        logic                wrap;
        span = region_span();
        top  = span - 6'd1;
        if (cur_phase[1])
        begin
            wrap = (cur_word == '0);
            if (!wrap)
                cur_word = cur_word - 5'd1;
        end
        else
        begin
            wrap = (({1'b0, cur_word} + 6'd1) >= span);
            if (!wrap)
                cur_word = cur_word + 5'd1;
        end
        if (wrap)
        begin
            if (cur_phase == PH_S4S)
            begin
                run_active = 1'b0;
                put_beat(KIND_DONE, '0, '0, run_sig, test_sig);
                cur_phase = PH_S1;
                cur_word  = '0;
                return;
            end
            // test signature is frozen, replay starts from zero
            if (cur_phase == PH_S4)
            begin
                test_sig = run_sig;
                run_sig  = '0;
            end
            cur_phase = cur_phase + 3'd1;
            cur_word  = cur_phase[1] ? top[INDEX_W-1:0] : '0;
        end
        put_beat(KIND_READ, cur_word, '0, run_sig, '0);
    endfunction

    function automatic void check_ref();
        logic [DATA_W-1:0] r;
        r = ref_sig[{cur_phase[1:0], cur_word}];
        if (r != run_sig)
            put_beat(KIND_MISMATCH, cur_word, '0, run_sig, r);
    endfunction

    // Commands and reports caused by one input beat
    function automatic void march_step(input logic act, input logic [DATA_W-1:0] v);
        logic [INDEX_W-1:0] w;
        result_t            b;
        step_beats.delete();
        w = cur_word;
        if (act == ACTION_START)
        begin
            run_active = 1'b1;
            run_sig    = '0;
            cur_phase  = PH_S1;
            cur_word   = '0;
            second_rd  = 1'b0;
            put_beat(KIND_READ, '0, '0, '0, '0);
        end
        else if (run_active)
        begin
            case (cur_phase)
                PH_S1, PH_S3:
                begin
                    run_sig = misr_fold(run_sig, v);
                    put_beat(KIND_WRITE, w, ~v, run_sig, '0);
                    put_beat(KIND_WRITE, w, v, run_sig, '0);
                    put_beat(KIND_WRITE, w, ~v, run_sig, '0);
                    ref_sig[{cur_phase[1:0], w}] = run_sig;
                    next_word();
                end
                PH_S2, PH_S4:
                begin
                    run_sig = misr_fold(run_sig, v);
                    put_beat(KIND_WRITE, w, ~v, run_sig, '0);
                    if (!second_rd)
                    begin
                        second_rd = 1'b1;
                        put_beat(KIND_READ, w, '0, run_sig, '0);
                    end
                    else
                    begin
                        second_rd = 1'b0;
                        ref_sig[{cur_phase[1:0], w}] = run_sig;
                        next_word();
                    end
                end
                PH_S1S, PH_S3S:
                begin
                    run_sig = misr_fold(run_sig, (cur_phase == PH_S3S) ? ~v : v);
                    check_ref();
                    next_word();
                end
                default:
                begin
                    // S2S and S4S read each word twice
                    if (!second_rd)
                    begin
                        run_sig   = misr_fold(run_sig, (cur_phase == PH_S2S) ? ~v : v);
                        second_rd = 1'b1;
                        put_beat(KIND_READ, w, '0, run_sig, '0);
                    end
                    else
                    begin
                        run_sig   = misr_fold(run_sig, (cur_phase == PH_S2S) ? v : ~v);
                        second_rd = 1'b0;
                        check_ref();
                        next_word();
                    end
                end
            endcase
        end
        if (step_beats.size() != 0)
        begin
            b      = step_beats.pop_back();
            b.last = 1'b1;
            step_beats.push_back(b);
        end
    endfunction

    // Accepted input beat: predict, track memory, queue expected commands
    function automatic void accept_beat(input logic act, input logic [DATA_W-1:0] data,
                                        input row_chk_t chk);
        result_t b;
        march_step(act, data);
        if (act == ACTION_START || step_beats.size() != 0)
            fed_items++;
        foreach (step_beats[i])
        begin
            b = step_beats[i];
            if (b.kind == KIND_WRITE)
                mem_word[b.word_index] = b.write_data;
            if (b.kind == KIND_READ)
                rd_addr = b.word_index;
            if (chk == CHK_MODEL)
                pending_cmds.push_back(b);
        end
        // a start always opens with a read of word 0 in S1
        if (chk == CHK_FIRST_READ)
        begin
            b.kind       = KIND_READ;
            b.word_index = '0;
            b.write_data = '0;
            b.signature  = '0;
            b.expected   = '0;
            b.phase      = PH_S1;
            b.last       = 1'b1;
            pending_cmds.push_back(b);
        end
    endfunction

    function automatic void add_row(input logic act, input logic [DATA_W-1:0] data,
                                    input row_chk_t chk);
        tbl_act.push_back(act);
        tbl_data.push_back(data);
        tbl_chk.push_back(chk);
    endfunction

    function automatic void log_fail(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // Drive one input beat at the falling edge, wait for it to be taken
    task automatic send_beat(input logic act, input logic [DATA_W-1:0] data,
                             input row_chk_t chk);
        if (fed_items < 150)
        begin
            send_gap_pct = 29;
            recv_gap_pct = 47;
        end
        else if (fed_items < 300)
        begin
            send_gap_pct = 47;
            recv_gap_pct = 29;
        end
        else
        begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
        end
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push      = 1'b1;
        action    = act;
        read_data = data;
        @(posedge clk);
        while (full)
            @(posedge clk);
        accept_beat(act, data, chk);
    endtask

    // Stop pushing and let every expected beat come out, plus slack for dropped beats
    task automatic quiesce();
        @(negedge clk);
        push = 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_region(input logic [REGION_W-1:0] val);
        quiesce();
        @(negedge clk);
        region_words_we = 1'b1;
        region_words    = val;
        @(negedge clk);
        region_words_we = 1'b0;
        region_reg      = val;
    endtask

    // Receiver stalls
    always @(negedge clk)
        pop = ($urandom_range(0, 99) >= recv_gap_pct);

    // Result checker
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && pop && !empty)
        begin
            got.kind       = kind;
            got.word_index = word_index;
            got.write_data = write_data;
            got.signature  = signature;
            got.expected   = expected;
            got.phase      = phase;
            got.last       = last;
            if (pending_cmds.size() == 0)
            begin
                log_fail($sformatf("%0t: unexpected beat kind=%0d idx=%0d ph=%0d",
                                   $realtime, got.kind, got.word_index, got.phase));
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (got.kind !== want.kind || got.word_index !== want.word_index ||
                    got.write_data !== want.write_data || got.signature !== want.signature ||
                    got.expected !== want.expected || got.phase !== want.phase ||
                    got.last !== want.last)
                begin
                    log_fail($sformatf({"%0t: mismatch\n",
                                        "  exp kind=%0d idx=%0d wd=%h sig=%h ref=%h ph=%0d last=%0d\n",
                                        "  got kind=%0d idx=%0d wd=%h sig=%h ref=%h ph=%0d last=%0d"},
                                       $realtime,
                                       want.kind, want.word_index, want.write_data, want.signature,
                                       want.expected, want.phase, want.last,
                                       got.kind, got.word_index, got.write_data, got.signature,
                                       got.expected, got.phase, got.last));
                end
            end
        end
    end

    // Watchdog: cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned        run_idx;
        logic [REGION_W-1:0] rv;
        mem_mode_t          mode;
        logic [DATA_W-1:0]  v;
        for (int i = 0; i < 128; i++)
            ref_sig[i] = '0;
        for (int i = 0; i < 32; i++)
            mem_word[i] = '0;

        // Directed rows, one-word region: idle data, restart, every element
        add_row(ACTION_DATA,  32'hFFFF_FFFF, CHK_SILENT);
        add_row(ACTION_START, 32'h0000_0000, CHK_FIRST_READ);
        add_row(ACTION_DATA,  32'h0000_0000, CHK_MODEL);
        add_row(ACTION_START, 32'hFFFF_FFFF, CHK_FIRST_READ);
        add_row(ACTION_DATA,  32'h0000_0000, CHK_MODEL);
        add_row(ACTION_DATA,  32'hFFFF_FFFF, CHK_MODEL);
        add_row(ACTION_DATA,  32'hFFFF_FFFF, CHK_MODEL);
        add_row(ACTION_DATA,  32'h8000_0000, CHK_MODEL);
        add_row(ACTION_DATA,  32'h0000_0001, CHK_MODEL);
        add_row(ACTION_DATA,  32'h7FFF_FFFF, CHK_MODEL);
        add_row(ACTION_DATA,  32'h0000_0000, CHK_MODEL);
        add_row(ACTION_DATA,  32'hFFFF_FFFF, CHK_MODEL);
        add_row(ACTION_DATA,  32'hFFFF_FFFF, CHK_MODEL);
        add_row(ACTION_DATA,  32'h5555_5555, CHK_MODEL);
        add_row(ACTION_DATA,  32'hAAAA_AAAA, CHK_MODEL);
        add_row(ACTION_DATA,  32'h1234_5678, CHK_MODEL);
        add_row(ACTION_DATA,  32'h0000_0000, CHK_SILENT);

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // region 0 behaves as a single word
        set_region(6'd0);
        foreach (tbl_act[i])
            send_beat(tbl_act[i], tbl_data[i], tbl_chk[i]);

        // Random runs: full size once, then small regions
        run_idx = 0;
        while (fed_items < ITEM_TARGET || run_idx < 3)
        begin
            if (run_idx == 0)
                rv = 6'd63;
            else if (run_idx == 1)
                rv = 6'd1;
            else
                rv = 6'($urandom_range(1, 5));
            set_region(rv);

            if (run_idx == 0)
                mode = MEM_GOOD;
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: mode = MEM_GOOD;
                    5, 6, 7:       mode = MEM_FAULT;
                    default:       mode = MEM_NOISE;
                endcase
            end

            // memory contents, with solid patterns now and then
            for (int i = 0; i < 32; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       mem_word[i] = '0;
                    1:       mem_word[i] = '1;
                    default: mem_word[i] = $urandom();
                endcase
            end

            // stray data while idle is dropped
            repeat ($urandom_range(0, 2)) send_beat(ACTION_DATA, $urandom(), CHK_MODEL);

            send_beat(ACTION_START, $urandom(), CHK_MODEL);
            while (run_active)
            begin
                if (region_span() <= 6'd8 && $urandom_range(0, 99) < 2)
                begin
                    send_beat(ACTION_START, $urandom(), CHK_MODEL);
                end
                else
                begin
                    v = mem_word[rd_addr];
                    if (mode == MEM_NOISE)
                        v = $urandom();
                    else if (mode == MEM_FAULT && $urandom_range(0, 99) < 3)
                        v = v ^ (32'd1 << $urandom_range(0, 31));
                    send_beat(ACTION_DATA, v, CHK_MODEL);
                end
            end
            run_idx++;
        end

        quiesce();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
